@@ hdl/ffba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, constants and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ADDR_W = 18;
  localparam int REQ_W  = 19;
  localparam int STS_W  = 2;

  localparam int DEF_POOL_BYTES   = 256 * 1024;
  localparam int DEF_HEADER_BYTES = 12;
  localparam int DEF_MAX_BLOCKS   = 1024;

  localparam int ALIGN_MASK  = 7;
  localparam int SPLIT_SLACK = 16;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_NO_MEM    = 2'd1;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] bytes;
    logic              free;
  } blk_t;

  typedef enum logic {
    RD_I,
    RD_KM1
  } rsel_e;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_SPLIT,
    WR_ALLOC,
    WR_PREV
  } wsel_e;

  typedef struct packed {
    logic             load_req;
    logic             rd_en;
    rsel_e            rd_sel;
    logic             wr_en;
    wsel_e            wr_sel;
    logic             inc_i;
    logic             latch_hit;
    logic             init_k;
    logic             dec_k;
    logic             ent_split;
    logic             inc_cnt;
    logic             clr_merge;
    logic             merge_step;
    logic             set_cnt_w;
    logic             set_res_addr;
    logic             out_load;
    logic [STS_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic rel_noop;
    logic is_rel;
    logic match;
    logic split_ok;
    logic need_shift;
    logic more_shift;
    logic last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/ffba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: table scan, entry shift, split, merge pass and response.
// ----------------------------------------------------------------------------
module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT_WR,
    S_ALLOC_WR,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_MERGE_FIN,
    S_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [STS_W-1:0] status_q, status_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.res_status = status_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          status_d = ST_OK;
          state_d  = sts_i.rel_noop ? S_RESP : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_I;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.match) begin
          cmd_o.latch_hit = 1'b1;
          if (sts_i.is_rel) begin
            cmd_o.clr_merge = 1'b1;
            state_d = S_MERGE_RD;
          end else if (sts_i.split_ok) begin
            cmd_o.init_k = 1'b1;
            state_d = sts_i.need_shift ? S_SHIFT_RD : S_SPLIT_WR;
          end else begin
            state_d = S_ALLOC_WR;
          end
        end else if (sts_i.last) begin
          status_d = sts_i.is_rel ? ST_NOT_FOUND : ST_NO_MEM;
          state_d  = S_RESP;
        end else begin
          cmd_o.inc_i = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_KM1;
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.dec_k  = 1'b1;
        state_d = sts_i.more_shift ? S_SHIFT_RD : S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_SPLIT;
        cmd_o.ent_split = 1'b1;
        cmd_o.inc_cnt   = 1'b1;
        state_d = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd_o.wr_en        = 1'b1;
        cmd_o.wr_sel       = WR_ALLOC;
        cmd_o.set_res_addr = 1'b1;
        state_d = S_RESP;
      end
      S_MERGE_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_I;
        state_d = S_MERGE_CHK;
      end
      S_MERGE_CHK: begin
        cmd_o.merge_step = 1'b1;
        if (sts_i.last) begin
          state_d = S_MERGE_FIN;
        end else begin
          cmd_o.inc_i = 1'b1;
          state_d = S_MERGE_RD;
        end
      end
      S_MERGE_FIN: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_PREV;
        cmd_o.set_cnt_w = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ffba_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_dp
// Block table memory, scan/merge registers and the result register.
// ----------------------------------------------------------------------------
module ffba_dp
  import ffba_pkg::*;
#(
  parameter int POOL_BYTES   = DEF_POOL_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_op_i,
  input  wire  [REQ_W-1:0]  in_req_i,
  input  wire  [ADDR_W-1:0] in_addr_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic [STS_W-1:0]  out_status_o
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = REQ_W + 1;

  localparam logic [ADDR_W-1:0] HDR       = ADDR_W'(HEADER_BYTES);
  localparam logic [CMP_W-1:0]  ALN       = CMP_W'(ALIGN_MASK);
  localparam logic [CMP_W-1:0]  SPLIT_ADD = CMP_W'(HEADER_BYTES + SPLIT_SLACK);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BLOCKS);
  localparam blk_t RST_ENT = '{start: '0, bytes: ADDR_W'(POOL_BYTES - HEADER_BYTES),
                               free: 1'b1};

  blk_t mem [MAX_BLOCKS];

  logic              op_q;
  logic [CMP_W-1:0]  n_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  i_q, k_q, w_q, cnt_q;
  logic [IDX_W-1:0]  hit_q;
  blk_t              ent_q, prev_q, rdata_q;
  logic              init_q, rd0_q;
  logic [ADDR_W-1:0] res_addr_q;

  blk_t              rd_ent;
  logic              free_eff, absorb;
  logic [CMP_W-1:0]  n1, n_new;
  logic [CNT_W-1:0]  k_m1, hit_p1;
  logic [IDX_W-1:0]  raddr, waddr;
  blk_t              wdata;
  logic              we;

  // rounded size keeps one extra bit so the largest request cannot wrap
  assign rd_ent   = rd0_q ? RST_ENT : rdata_q;
  assign free_eff = rd_ent.free | (i_q[IDX_W-1:0] == hit_q);
  assign absorb   = (w_q != '0) && prev_q.free && free_eff;
  assign n1       = (in_req_i == '0) ? CMP_W'(1) : {1'b0, in_req_i};
  assign n_new    = (n1 + ALN) & ~ALN;
  assign k_m1     = k_q - CNT_W'(1);
  assign hit_p1   = CNT_W'(hit_q) + CNT_W'(1);

  always_comb begin
    sts_o            = '0;
    sts_o.rel_noop   = (in_op_i == OP_RELEASE) && (in_addr_i == '0);
    sts_o.is_rel     = (op_q == OP_RELEASE);
    if (op_q == OP_RELEASE) begin
      sts_o.match = ((rd_ent.start + HDR) == addr_q);
    end else begin
      sts_o.match = rd_ent.free && ({2'b00, rd_ent.bytes} >= n_q);
    end
    sts_o.split_ok   = ({2'b00, rd_ent.bytes} >= (n_q + SPLIT_ADD))
                       && (cnt_q < CNT_MAX);
    sts_o.need_shift = cnt_q > (i_q + CNT_W'(1));
    sts_o.more_shift = k_m1 > hit_p1;
    sts_o.last       = (i_q + CNT_W'(1)) == cnt_q;
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

  // memory ports
  always_comb begin
    raddr = (cmd_i.rd_sel == RD_KM1) ? k_m1[IDX_W-1:0] : i_q[IDX_W-1:0];
    we    = cmd_i.wr_en;
    waddr = hit_q;
    wdata = ent_q;
    case (cmd_i.wr_sel)
      WR_SHIFT: begin
        waddr = k_q[IDX_W-1:0];
        wdata = rd_ent;
      end
      WR_SPLIT: begin
        waddr = hit_p1[IDX_W-1:0];
        wdata.start = ent_q.start + HDR + n_q[ADDR_W-1:0];
        wdata.bytes = ent_q.bytes - n_q[ADDR_W-1:0] - HDR;
        wdata.free  = 1'b1;
      end
      WR_ALLOC: begin
        waddr = hit_q;
        wdata = ent_q;
        wdata.free = 1'b0;
      end
      default: begin
        waddr = k_m1[IDX_W-1:0];
        waddr = IDX_W'(w_q - CNT_W'(1));
        wdata = prev_q;
      end
    endcase
    // merge pass pushes the finished run before starting a new one
    if (cmd_i.merge_step && !absorb && (w_q != '0)) begin
      we    = 1'b1;
      waddr = IDX_W'(w_q - CNT_W'(1));
      wdata = prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_W'(1);
      init_q      <= 1'b0;
      rd0_q       <= 1'b0;
      out_valid_o <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      w_q         <= '0;
    end else begin
      if (we && (waddr == '0)) begin
        init_q <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd0_q <= (raddr == '0) && !(init_q || (we && (waddr == '0)));
      end
      if (cmd_i.load_req || cmd_i.clr_merge) begin
        i_q <= '0;
      end else if (cmd_i.inc_i) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.init_k) begin
        k_q <= cnt_q;
      end else if (cmd_i.dec_k) begin
        k_q <= k_m1;
      end
      if (cmd_i.clr_merge) begin
        w_q <= '0;
      end else if (cmd_i.merge_step && !absorb) begin
        w_q <= w_q + CNT_W'(1);
      end
      if (cmd_i.inc_cnt) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.set_cnt_w) begin
        cnt_q <= w_q;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q       <= in_op_i;
      n_q        <= n_new;
      addr_q     <= in_addr_i;
      res_addr_q <= '0;
    end
    if (cmd_i.latch_hit) begin
      hit_q <= i_q[IDX_W-1:0];
      ent_q <= rd_ent;
    end else if (cmd_i.ent_split) begin
      ent_q.bytes <= n_q[ADDR_W-1:0];
    end
    if (cmd_i.set_res_addr) begin
      res_addr_q <= ent_q.start + HDR;
    end
    if (cmd_i.merge_step) begin
      if (absorb) begin
        prev_q.bytes <= prev_q.bytes + HDR + rd_ent.bytes;
      end else begin
        prev_q <= '{start: rd_ent.start, bytes: rd_ent.bytes, free: free_eff};
      end
    end
    if (cmd_i.out_load) begin
      out_addr_o   <= res_addr_q;
      out_status_o <= cmd_i.res_status;
    end
  end

endmodule
`default_nettype wire

@@ hdl/first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator with splitting and coalescing over a fixed byte pool.
// ----------------------------------------------------------------------------
// One transaction at a time is worked on; the block table lives in a
// single-port-read, single-port-write memory with registered read data, so
// each table entry visited is first read and then checked or written. An
// allocate scans the table and may shift entries to open a slot; a release
// scans the table and, on a match, makes a merge pass over every entry. No
// clearing pass follows reset: the entry count bounds every access and
// entry 0 reads as the whole free pool until first written. A result
// waits in an output register, so the next request can be taken while
// the previous response is still stalled.
// Status codes: 0 ok, 1 out of memory, 2 release address not found.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int POOL_BYTES   = DEF_POOL_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // request_bytes[18:0], release_address[36:19], zero
  input  wire  [0:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // granted_address[17:0], zero
  output logic [1:0]  m_axis_tuser    // status
);

  cmd_t              cmd;
  sts_t              sts;
  logic [ADDR_W-1:0] out_addr;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffba_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tuser[0]),
    .in_req_i     (s_axis_tdata[REQ_W-1:0]),
    .in_addr_i    (s_axis_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, out_addr};

endmodule
`default_nettype wire
